FILE: src/midi_note_voice_allocator_macros.svh
// Assertion macros for the MIDI note voice allocator.
// Used by midi_note_voice_allocator.sv; expects clk_i and rst_ni in scope.
`ifndef MIDI_NOTE_VOICE_ALLOCATOR_MACROS_SVH
`define MIDI_NOTE_VOICE_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MNVA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MNVA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/mnva_pkg.sv
// Package for the MIDI note voice allocator: codes, widths and defaults.
// No dependencies; imported by midi_note_voice_allocator.
`timescale 1ns / 1ps

package mnva_pkg;

  // Default voice count
  localparam int VOICES_DEF = 8;

  // Stream word widths
  localparam int S_DATA_W = 40;  // data_byte[7:0], now_ms[39:8]
  localparam int M_DATA_W = 16;  // action[1:0], voice_index[4:2], note_number[11:5]

  // MIDI status nibbles
  localparam logic [7:0] STAT_MASK     = 8'hF0;
  localparam logic [7:0] STAT_NOTE_ON  = 8'h90;
  localparam logic [7:0] STAT_NOTE_OFF = 8'h80;

  // Parser phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_NOTE = 2'd1;
  localparam logic [1:0] PH_VEL  = 2'd2;

  // Result actions
  localparam logic [1:0] ACT_ASSIGN  = 2'd0;
  localparam logic [1:0] ACT_STEAL   = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;
  localparam logic [1:0] ACT_NOMATCH = 2'd3;

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

endpackage

FILE: src/midi_note_voice_allocator.sv
// MIDI note voice allocator: byte parser, voice table and walk sequencer.
// Depends on mnva_pkg and midi_note_voice_allocator_macros.svh.
`timescale 1ns / 1ps
`include "midi_note_voice_allocator_macros.svh"

// Usage
//   Slave stream takes one raw MIDI byte per word with the current ms tick.
//   Master stream gives one word per completed Note On or Note Off:
//   the action, the voice index (low 3 bits) and the note number.
//   Bytes that finish no event give no word and leave the parser ready.
// Sequencing
//   A Note On with a free voice: the voice is written on accept, then the emit
//   state loads the output register. A Note Off, or a Note On with all voices
//   busy, first walks the voice table, one voice per cycle through a single
//   32-bit timestamp comparator. No new byte is taken during the walk.
// Reset
//   Parser returns to idle and all voices are free; no clearing pass.
// Stall
//   A finished word waits in the output register while tready is low; the
//   block keeps taking bytes until a second result is ready, then holds in
//   the emit state until the output register frees up.
module midi_note_voice_allocator #(
  parameter int VOICES = mnva_pkg::VOICES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tdata: data_byte[7:0], now_ms[39:8]
  input  logic [mnva_pkg::S_DATA_W-1:0] s_axis_tdata,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: action[1:0], voice_index[4:2], note_number[11:5], zero[15:12]
  output logic [mnva_pkg::M_DATA_W-1:0] m_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready
);
  import mnva_pkg::*;

  localparam int IW = $clog2(VOICES);

  // Input word fields
  logic [7:0]  in_byte;
  logic [31:0] in_now;
  logic        s_acc;
  assign in_byte = s_axis_tdata[7:0];
  assign in_now  = s_axis_tdata[39:8];

  // Control and payload registers
  logic [1:0]    state_q, state_d;
  logic [1:0]    phase_q, phase_d;
  logic          pend_on_q, pend_on_d;
  logic [6:0]    pend_note_q, pend_note_d;
  logic [31:0]   now_q, now_d;
  logic          walk_on_q, walk_on_d;
  logic [IW-1:0] walk_idx_q, walk_idx_d;
  logic [IW-1:0] pick_q, pick_d;
  logic          found_q, found_d;
  logic [31:0]   best_q, best_d;
  logic [1:0]    res_act_q, res_act_d;
  logic [IW-1:0] res_idx_q, res_idx_d;
  logic          m_valid_q, m_valid_d;
  logic [M_DATA_W-1:0] m_data_q, m_data_d;

  // Voice table: busy bits reset, note and stamp only read when busy
  logic [VOICES-1:0] busy_q, busy_d;
  logic [6:0]        vnote_q  [VOICES];
  logic [31:0]       vstamp_q [VOICES];

  // Voice table write port
  logic          vwr_en;
  logic [IW-1:0] vwr_idx;
  logic          vwr_busy;
  logic [6:0]    vwr_note;
  logic [31:0]   vwr_stamp;

  // Lowest free voice
  logic          any_free;
  logic [IW-1:0] free_idx;
  always_comb begin
    free_idx = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        free_idx = IW'(i);
      end
    end
    any_free = ~&busy_q;
  end

  // Shared compare unit on the voice under the walk index
  logic        cur_busy;
  logic [6:0]  cur_note;
  logic [31:0] cur_stamp;
  logic        cand, better, walk_last;
  assign cur_busy  = busy_q[walk_idx_q];
  assign cur_note  = vnote_q[walk_idx_q];
  assign cur_stamp = vstamp_q[walk_idx_q];
  assign cand      = walk_on_q || (cur_busy && (cur_note == pend_note_q));
  assign better    = cand && (!found_q || (cur_stamp < best_q));
  assign walk_last = (walk_idx_q == IW'(VOICES - 1));

  // Output word packing
  logic [IW+2:0] res_idx_ext;
  assign res_idx_ext = (IW + 3)'(res_idx_q);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Parser and sequencer
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    pend_on_d   = pend_on_q;
    pend_note_d = pend_note_q;
    now_d       = now_q;
    walk_on_d   = walk_on_q;
    walk_idx_d  = walk_idx_q;
    pick_d      = pick_q;
    found_d     = found_q;
    best_d      = best_q;
    res_act_d   = res_act_q;
    res_idx_d   = res_idx_q;
    m_valid_d   = m_valid_q;
    m_data_d    = m_data_q;
    vwr_en      = 1'b0;
    vwr_idx     = pick_q;
    vwr_busy    = 1'b0;
    vwr_note    = '0;
    vwr_stamp   = '0;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          case (phase_q)
            PH_IDLE: begin
              if ((in_byte & STAT_MASK) == STAT_NOTE_ON) begin
                pend_on_d = 1'b1;
                phase_d   = PH_NOTE;
              end else if ((in_byte & STAT_MASK) == STAT_NOTE_OFF) begin
                pend_on_d = 1'b0;
                phase_d   = PH_NOTE;
              end
            end
            PH_NOTE: begin
              pend_note_d = in_byte[6:0];
              if (pend_on_q) begin
                phase_d = PH_VEL;
              end else begin
                // Note Off: walk for the oldest matching voice
                phase_d    = PH_IDLE;
                walk_on_d  = 1'b0;
                walk_idx_d = '0;
                found_d    = 1'b0;
                state_d    = ST_WALK;
              end
            end
            PH_VEL: begin
              phase_d = PH_IDLE;
              now_d   = in_now;
              if (any_free) begin
                vwr_en    = 1'b1;
                vwr_idx   = free_idx;
                vwr_busy  = 1'b1;
                vwr_note  = pend_note_q;
                vwr_stamp = in_now;
                res_act_d = ACT_ASSIGN;
                res_idx_d = free_idx;
                state_d   = ST_EMIT;
              end else begin
                // All busy: walk for the smallest stamp
                walk_on_d  = 1'b1;
                walk_idx_d = '0;
                found_d    = 1'b0;
                state_d    = ST_WALK;
              end
            end
            default: begin
              phase_d = PH_IDLE;
            end
          endcase
        end
      end
      ST_WALK: begin
        if (better) begin
          pick_d  = walk_idx_q;
          best_d  = cur_stamp;
          found_d = 1'b1;
        end
        walk_idx_d = walk_idx_q + 1'b1;
        if (walk_last) begin
          state_d = ST_EMIT;
          vwr_idx = pick_d;
          if (walk_on_q) begin
            vwr_en    = 1'b1;
            vwr_busy  = 1'b1;
            vwr_note  = pend_note_q;
            vwr_stamp = now_q;
            res_act_d = ACT_STEAL;
            res_idx_d = pick_d;
          end else if (found_d) begin
            vwr_en    = 1'b1;
            res_act_d = ACT_RELEASE;
            res_idx_d = pick_d;
          end else begin
            res_act_d = ACT_NOMATCH;
            res_idx_d = '0;
          end
        end
      end
      ST_EMIT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {4'b0, pend_note_q, res_idx_ext[2:0], res_act_q};
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Busy bits
  always_comb begin
    busy_d = busy_q;
    if (vwr_en) begin
      busy_d[vwr_idx] = vwr_busy;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_IDLE;
      pend_on_q   <= 1'b0;
      pend_note_q <= '0;
      walk_on_q   <= 1'b0;
      walk_idx_q  <= '0;
      found_q     <= 1'b0;
      m_valid_q   <= 1'b0;
      busy_q      <= '0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      pend_on_q   <= pend_on_d;
      pend_note_q <= pend_note_d;
      walk_on_q   <= walk_on_d;
      walk_idx_q  <= walk_idx_d;
      found_q     <= found_d;
      m_valid_q   <= m_valid_d;
      busy_q      <= busy_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    now_q     <= now_d;
    pick_q    <= pick_d;
    best_q    <= best_d;
    res_act_q <= res_act_d;
    res_idx_q <= res_idx_d;
    m_data_q  <= m_data_d;
  end

  // Voice note and stamp table
  always_ff @(posedge clk_i) begin
    if (vwr_en) begin
      vnote_q[vwr_idx]  <= vwr_note;
      vstamp_q[vwr_idx] <= vwr_stamp;
    end
  end

  // Checks
  logic walk_end, emit_go;
  assign walk_end = (state_q == ST_WALK) && walk_last;
  assign emit_go  = (state_q == ST_EMIT) && (!m_valid_q || m_axis_tready);

  `MNVA_ASSERT_NOW(a_acc_idle, s_acc, state_q == ST_IDLE, "byte taken outside idle")
  `MNVA_ASSERT_NEXT(a_on_walk_steals, walk_end && walk_on_q, res_act_q == ACT_STEAL, "no steal")
  `MNVA_ASSERT_NEXT(a_emit_loads, emit_go, m_axis_tvalid && state_q == ST_IDLE, "not loaded")
  `MNVA_ASSERT_NEXT(a_walk_done, walk_end, state_q == ST_EMIT, "walk did not end in emit")

endmodule
